@@ src/fhlp_pkg.sv @@
// Shared types and constants for the fixed-Huffman literal packer.
package fhlp_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned FILL_BITS = 5;
  localparam int unsigned CODE_BITS = 9;
  localparam int unsigned LEN_BITS  = 4;
  localparam logic [7:0]  LIT_SPLIT = 8'd144;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_LITERAL = 2'd1,
    KIND_END     = 2'd2,
    KIND_FLUSH   = 2'd3
  } kind_t;

  // Bits to append (LSB first), how many, and whether this item is a flush.
  typedef struct packed {
    logic [CODE_BITS-1:0] bits;
    logic [LEN_BITS-1:0]  len;
    logic                 flush;
  } code_t;

endpackage

@@ src/fixed_huffman_literal_packer.sv @@
// An accepted item is held in the input register; its code is then merged into the accumulator or word register.
// Throughput: one item per cycle unless the word register stalls; the input register and the
// word register form a two-stage pipeline and the accumulator update is a single shift and OR.
// A stalled word register holds back the input register, so item_ready drops only then.
// Reset (rst, synchronous) empties both stages and clears the accumulator and fill count.
module fixed_huffman_literal_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic        final_block,
  output logic        word_valid,
  input  logic        word_ready,
  output logic [31:0] out_word,
  output logic [2:0]  byte_count,
  output logic        stream_end
);

  logic            stage_valid;
  logic [1:0]      stage_kind;
  logic [7:0]      stage_byte;
  logic            stage_final;
  logic            advance;
  fhlp_pkg::code_t code;

  assign item_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      stage_valid <= 1'b1;
      stage_kind  <= kind;
      stage_byte  <= data_byte;
      stage_final <= final_block;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  fhlp_code u_code (
    .kind        (stage_kind),
    .data_byte   (stage_byte),
    .final_block (stage_final),
    .code        (code)
  );

  fhlp_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .code_valid (stage_valid),
    .code       (code),
    .advance    (advance),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .out_word   (out_word),
    .byte_count (byte_count),
    .stream_end (stream_end)
  );

endmodule

@@ src/fhlp_code.sv @@
// Maps one item to the bit string it appends to the deflate stream.
module fhlp_code (
  input  logic [1:0]      kind,
  input  logic [7:0]      data_byte,
  input  logic            final_block,
  output fhlp_pkg::code_t code
);

  logic [8:0] huff;
  logic [8:0] huff_rev8;
  logic [8:0] huff_rev9;

  // Fixed literal code: 0x30+v for the low range, 0x100+v above the split.
  always_comb begin
    if (data_byte < fhlp_pkg::LIT_SPLIT) begin
      huff = {1'b0, 8'h30 + data_byte};
    end else begin
      huff = {1'b1, data_byte};
    end
    huff_rev8 = '0;
    huff_rev9 = '0;
    for (int i = 0; i < 8; i++) begin
      huff_rev8[i] = huff[7-i];
    end
    for (int i = 0; i < 9; i++) begin
      huff_rev9[i] = huff[8-i];
    end
  end

  always_comb begin
    code = '0;
    case (fhlp_pkg::kind_t'(kind))
      fhlp_pkg::KIND_HEADER: begin
        // BFINAL then BTYPE=01, LSB first
        code.bits = {6'd0, 1'b0, 1'b1, final_block};
        code.len  = 4'd3;
      end
      fhlp_pkg::KIND_LITERAL: begin
        if (data_byte < fhlp_pkg::LIT_SPLIT) begin
          code.bits = huff_rev8;
          code.len  = 4'd8;
        end else begin
          code.bits = huff_rev9;
          code.len  = 4'd9;
        end
      end
      fhlp_pkg::KIND_END: begin
        code.bits = '0;
        code.len  = 4'd7;
      end
      fhlp_pkg::KIND_FLUSH: begin
        code.flush = 1'b1;
      end
      default: begin
        code = '0;
      end
    endcase
  end

endmodule

@@ src/fhlp_pack.sv @@
// Bit accumulator and output word register.
module fhlp_pack (
  input  logic            clk,
  input  logic            rst,
  input  logic            code_valid,
  input  fhlp_pkg::code_t code,
  output logic            advance,
  output logic            word_valid,
  input  logic            word_ready,
  output logic [31:0]     out_word,
  output logic [2:0]      byte_count,
  output logic            stream_end
);

  logic [31:0] acc;
  logic [4:0]  fill;
  logic [39:0] merged;
  logic [5:0]  fill_sum;
  logic [2:0]  flush_count;

  assign advance = !word_valid || word_ready;

  always_comb begin
    merged      = {8'd0, acc} | (40'(code.bits) << fill);
    fill_sum    = {1'b0, fill} + {2'd0, code.len};
    flush_count = 3'(({1'b0, fill} + 6'd7) >> 3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      fill       <= '0;
      word_valid <= 1'b0;
    end else if (code_valid && advance) begin
      if (code.flush) begin
        word_valid <= (fill != '0);
        out_word   <= acc;
        byte_count <= flush_count;
        stream_end <= 1'b1;
        acc        <= '0;
        fill       <= '0;
      end else if (fill_sum >= 6'(fhlp_pkg::WORD_BITS)) begin
        word_valid <= 1'b1;
        out_word   <= merged[31:0];
        byte_count <= 3'd4;
        stream_end <= 1'b0;
        acc        <= {24'd0, merged[39:32]};
        fill       <= 5'(fill_sum - 6'(fhlp_pkg::WORD_BITS));
      end else begin
        word_valid <= 1'b0;
        acc        <= merged[31:0];
        fill       <= fill_sum[4:0];
      end
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

endmodule

@@ src/fhlp_checker.sv @@
// Port-level checks for the fixed-Huffman literal packer, bound to the top level.
module fhlp_checker (
  input logic        clk,
  input logic        rst,
  input logic        word_valid,
  input logic        word_ready,
  input logic [31:0] out_word,
  input logic [2:0]  byte_count,
  input logic        stream_end
);

  // a stalled transaction keeps its word
  assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_ready |=> word_valid && $stable(out_word))
    else $error("output word changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    word_valid |-> byte_count != 3'd0 && byte_count <= 3'd4)
    else $error("byte_count out of range");

  // only a flush may deliver a partial word
  assert property (@(posedge clk) disable iff (rst)
    word_valid && !stream_end |-> byte_count == 3'd4)
    else $error("partial word without stream_end");

  assert property (@(posedge clk)
    rst |=> !word_valid)
    else $error("word_valid set after reset");

endmodule

bind fixed_huffman_literal_packer fhlp_checker u_fhlp_checker (
  .clk        (clk),
  .rst        (rst),
  .word_valid (word_valid),
  .word_ready (word_ready),
  .out_word   (out_word),
  .byte_count (byte_count),
  .stream_end (stream_end)
);

@@ tb/sv/fixed_huffman_literal_packer_tb.sv @@
// Self-checking testbench for the fixed-Huffman literal packer, with a bit-packing predictor.
module fixed_huffman_literal_packer_tb;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        last;
  } packed_word_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic        final_block;
  logic        word_valid;
  logic        word_ready;
  logic [31:0] out_word;
  logic [2:0]  byte_count;
  logic        stream_end;

  fixed_huffman_literal_packer dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .kind        (kind),
    .data_byte   (data_byte),
    .final_block (final_block),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .out_word    (out_word),
    .byte_count  (byte_count),
    .stream_end  (stream_end)
  );

  // Predictor state: pending bits and how many there are.
  logic [31:0]  pend_bits;
  int unsigned  pend_fill;
  packed_word_t expected_words[$];
  int unsigned  fail_count;

  // Idling controls; the long receiver hold is requested by id and counted in the sink.
  bit          src_idle_on;
  bit          sink_idle_on;
  int unsigned hold_req;
  int unsigned hold_len;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [8:0] reverse_code(input logic [8:0] code, input int unsigned n);
    logic [8:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r[i] = code[n - 1 - i];
    return r;
  endfunction

  // Packs one item into the pending bits; returns 1 when it yields a word.
  function automatic bit pack_item(input fhlp_pkg::kind_t k, input logic [7:0] b,
                                   input logic fin, output packed_word_t w);
    logic [63:0] wide;
    logic [8:0]  code;
    int unsigned n;
    w = '0;
    code = '0;
    n = 0;
    case (k)
      fhlp_pkg::KIND_HEADER: begin
        code = {7'd1, fin};  // BFINAL, then BTYPE 01 LSB first
        n = 3;
      end
      fhlp_pkg::KIND_LITERAL: begin
        if (b < fhlp_pkg::LIT_SPLIT) begin
          code = reverse_code(9'h030 + {1'b0, b}, 8);
          n = 8;
        end else begin
          code = reverse_code(9'h190 + {1'b0, b} - {1'b0, fhlp_pkg::LIT_SPLIT}, 9);
          n = 9;
        end
      end
      fhlp_pkg::KIND_END: begin
        code = '0;
        n = 7;
      end
      default: begin
        if (pend_fill == 0) begin
          pend_bits = '0;
          return 1'b0;
        end
        w.word = pend_bits;
        w.nbytes = 3'((pend_fill + 7) / 8);
        w.last = 1'b1;
        pend_bits = '0;
        pend_fill = 0;
        return 1'b1;
      end
    endcase
    wide = {32'd0, pend_bits} | (64'(code) << pend_fill);
    pend_fill = pend_fill + n;
    if (pend_fill >= 32) begin
      w.word = wide[31:0];
      w.nbytes = 3'd4;
      w.last = 1'b0;
      pend_bits = wide[63:32];
      pend_fill = pend_fill - 32;
      return 1'b1;
    end
    pend_bits = wide[31:0];
    return 1'b0;
  endfunction

  // Offers one item and waits for its transaction; valid stays high for the next one.
  task automatic send_item(input fhlp_pkg::kind_t k, input logic [7:0] b, input logic fin);
    packed_word_t w;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    data_byte <= b;
    final_block <= fin;
    do @(posedge clk); while (!item_ready);
    if (pack_item(k, b, fin, w)) expected_words = {expected_words, w};
  endtask

  task automatic drain_words();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd143;
      2: return 8'd144;
      3: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic fhlp_pkg::kind_t any_kind();
    return fhlp_pkg::kind_t'($urandom_range(0, 3));
  endfunction

  // Result sink: checks each transaction and drives word_ready.
  initial begin : word_sink
    int unsigned  stall_left;
    int unsigned  hold_left;
    int unsigned  seen_req;
    packed_word_t w;
    stall_left = 0;
    hold_left = 0;
    seen_req = 0;
    word_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && word_valid && word_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word: expected none actual %h bytes %0d end %b",
                   $time, out_word, byte_count, stream_end);
          fail_count++;
        end else begin
          w = expected_words.pop_front();
          if (out_word !== w.word) begin
            $display("%0t out_word: expected %h actual %h", $time, w.word, out_word);
            fail_count++;
          end
          if (byte_count !== w.nbytes) begin
            $display("%0t byte_count: expected %0d actual %0d", $time, w.nbytes, byte_count);
            fail_count++;
          end
          if (stream_end !== w.last) begin
            $display("%0t stream_end: expected %b actual %b", $time, w.last, stream_end);
            fail_count++;
          end
        end
      end
      if (hold_req != seen_req) begin
        seen_req = hold_req;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        word_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        word_ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        word_ready <= 1'b0;
      end else begin
        word_ready <= 1'b1;
      end
    end
  end

  // Edges of the code table, every kind, empty and partial flushes of each byte count.
  task automatic test_directed();
    send_item(fhlp_pkg::KIND_FLUSH, 8'($urandom), 1'($urandom));
    send_item(fhlp_pkg::KIND_HEADER, 8'($urandom), 1'b1);
    send_item(fhlp_pkg::KIND_FLUSH, 8'($urandom), 1'($urandom));
    send_item(fhlp_pkg::KIND_HEADER, 8'($urandom), 1'b0);
    send_item(fhlp_pkg::KIND_LITERAL, 8'd0, 1'($urandom));
    send_item(fhlp_pkg::KIND_LITERAL, 8'd255, 1'($urandom));
    send_item(fhlp_pkg::KIND_FLUSH, 8'($urandom), 1'($urandom));
    send_item(fhlp_pkg::KIND_LITERAL, 8'd143, 1'($urandom));
    send_item(fhlp_pkg::KIND_END, 8'($urandom), 1'($urandom));
    send_item(fhlp_pkg::KIND_FLUSH, 8'($urandom), 1'($urandom));
    // exactly one word, then nothing left for the flush
    for (int i = 1; i <= 4; i++) send_item(fhlp_pkg::KIND_LITERAL, 8'(i), 1'($urandom));
    send_item(fhlp_pkg::KIND_FLUSH, 8'($urandom), 1'($urandom));
    // word with a carry into the next one
    send_item(fhlp_pkg::KIND_HEADER, 8'($urandom), 1'b1);
    repeat (3) send_item(fhlp_pkg::KIND_LITERAL, 8'd144, 1'($urandom));
    send_item(fhlp_pkg::KIND_END, 8'($urandom), 1'($urandom));
    send_item(fhlp_pkg::KIND_FLUSH, 8'($urandom), 1'($urandom));
    // 24 + 3 bits: partial flush of four bytes
    repeat (3) send_item(fhlp_pkg::KIND_LITERAL, 8'd100, 1'($urandom));
    send_item(fhlp_pkg::KIND_HEADER, 8'($urandom), 1'b0);
    send_item(fhlp_pkg::KIND_FLUSH, 8'($urandom), 1'($urandom));
  endtask

  // Well-formed blocks with random content, and some noise between them.
  task automatic test_random_blocks(input int unsigned n_items);
    int unsigned sent;
    int unsigned lits;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 5) == 0) begin
        send_item(any_kind(), 8'($urandom), 1'($urandom));
        sent++;
      end else begin
        send_item(fhlp_pkg::KIND_HEADER, 8'($urandom), 1'($urandom));
        lits = $urandom_range(0, 20);
        repeat (lits) send_item(fhlp_pkg::KIND_LITERAL, pick_byte(), 1'($urandom));
        send_item(fhlp_pkg::KIND_END, 8'($urandom), 1'($urandom));
        sent += lits + 2;
        if ($urandom_range(0, 2) == 0) begin
          send_item(fhlp_pkg::KIND_FLUSH, 8'($urandom), 1'($urandom));
          sent++;
        end
      end
    end
  endtask

  // Long receiver hold while literals keep coming, so the input stalls.
  task automatic test_backpressure();
    src_idle_on = 1'b0;
    hold_len = 150;
    hold_req++;
    repeat (40) send_item(fhlp_pkg::KIND_LITERAL, pick_byte(), 1'($urandom));
    send_item(fhlp_pkg::KIND_FLUSH, 8'($urandom), 1'($urandom));
    drain_words();
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_items(input int unsigned n_items);
    repeat (n_items) send_item(any_kind(), pick_byte(), 1'($urandom));
  endtask

  initial begin : stimulus
    fail_count = 0;
    pend_bits = '0;
    pend_fill = 0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    hold_req = 0;
    hold_len = 0;
    rst <= 1'b1;
    item_valid <= 1'b0;
    kind <= fhlp_pkg::KIND_HEADER;
    data_byte <= '0;
    final_block <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    drain_words();
    test_random_blocks(220);
    test_backpressure();
    test_random_items(60);
    // closing stretch with no idling on either side
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random_blocks(60);
    send_item(fhlp_pkg::KIND_FLUSH, 8'($urandom), 1'($urandom));

    drain_words();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
